// ===== hdl/apsp_pkg.sv =====
package apsp_pkg;

  localparam int MAX_NODES = 128;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int DIST_W    = 8;
  localparam int ADDR_W    = 2 * NODE_W;
  localparam int DEPTH     = MAX_NODES * MAX_NODES;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam dist_t UNREACH = 8'd255;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_EDGE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // write request from the sequencer to the matrix store
  typedef struct packed {
    logic  en;
    addr_t addr;
    dist_t data;
  } wr_req_t;

  // saturating distance add, unreachable absorbs
  function automatic dist_t sat_add(dist_t x, dist_t y);
    logic [DIST_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (x == UNREACH || y == UNREACH || s >= {1'b0, UNREACH}) begin
      return UNREACH;
    end
    return s[DIST_W-1:0];
  endfunction

endpackage

// ===== hdl/apsp_ram.sv =====
module apsp_ram (
  input  logic              clk,
  input  apsp_pkg::wr_req_t wr,
  input  apsp_pkg::addr_t   rd_addr_a,
  input  apsp_pkg::addr_t   rd_addr_b,
  output apsp_pkg::dist_t   rd_data_a,
  output apsp_pkg::dist_t   rd_data_b
);

  apsp_pkg::dist_t mem [apsp_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== hdl/all_pairs_shortest_path_max_detour.sv =====
// all-pairs shortest path store with a longest-detour query
//
// input channel s_axis: one beat per command, kind in tuser, arguments in tdata
//   begin (n): sets the node count (clamped to 128) and rewrites the n x n
//     matrix, zero on the diagonal, unreachable elsewhere
//   edge (a, b): sets both directions to one, ignored when an end is out of
//     range or a == b
//   query (a, b): runs floyd-warshall relaxation over the active nodes in
//     place, then scans every node i for dist(a,i) + dist(i,b),
//     both skipped for an out-of-range node
// the single matrix memory takes one write and two reads per cycle, so
// relaxation handles one matrix entry per cycle plus a row overhead
// (fetch of d(i,k) and pipeline drain)
// output channel m_axis: one result beat per query, held in an output
//   register; further commands are taken while it waits, a query that
//   finishes while it is still full waits until the receiver takes it
// reset: node count goes to zero, the output register empties; the matrix
//   is not cleared, a begin command writes it before any read
module all_pairs_shortest_path_max_detour (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // node_count[7:0], node_a[14:8], node_b[21:15], zero
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // route_length[7:0], unreachable[8], bad_request[9], zero
);

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FILL  = 4'd1;
  localparam logic [3:0] ST_EDGE1 = 4'd2;
  localparam logic [3:0] ST_EDGE2 = 4'd3;
  localparam logic [3:0] ST_RIK   = 4'd4;
  localparam logic [3:0] ST_ROW   = 4'd5;
  localparam logic [3:0] ST_RLAST = 4'd6;
  localparam logic [3:0] ST_SCAN  = 4'd7;
  localparam logic [3:0] ST_SLAST = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic [1:0] CMD_BEGIN_L = apsp_pkg::CMD_BEGIN;
  localparam logic [1:0] CMD_EDGE_L  = apsp_pkg::CMD_EDGE;
  localparam logic [1:0] CMD_QUERY_L = apsp_pkg::CMD_QUERY;

  logic [3:0] state;
  logic [3:0] state_next;

  // input beat unpacked
  logic [1:0]       cmd_in;
  logic [7:0]       cnt_in;
  apsp_pkg::node_t  a_in;
  apsp_pkg::node_t  b_in;
  apsp_pkg::cnt_t   cnt_clamped;
  logic             s_fire;
  logic             a_ok;
  logic             b_ok;

  assign cmd_in = s_axis_tuser;
  assign cnt_in = s_axis_tdata[7:0];
  assign a_in   = s_axis_tdata[14:8];
  assign b_in   = s_axis_tdata[21:15];
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  assign cnt_clamped = (cnt_in > 8'(apsp_pkg::MAX_NODES))
                       ? apsp_pkg::CNT_W'(apsp_pkg::MAX_NODES)
                       : apsp_pkg::CNT_W'(cnt_in);

  // control registers
  apsp_pkg::cnt_t  n_reg;
  apsp_pkg::node_t nm1;
  logic [apsp_pkg::CNT_W-1:0] n_dec;
  apsp_pkg::node_t qa;          // edge end a or query source
  apsp_pkg::node_t qb;          // edge end b or query destination
  apsp_pkg::node_t kk;
  apsp_pkg::node_t ii;
  apsp_pkg::node_t jj;
  apsp_pkg::node_t jp;          // column of the entry in flight
  logic            pend;        // read data for entry jp arrives this cycle
  logic            first;       // d(i,k) arrives this cycle
  apsp_pkg::dist_t dik;
  apsp_pkg::dist_t best;
  logic            unr;
  logic            bad;

  assign n_dec = n_reg - apsp_pkg::CNT_W'(1);
  assign nm1   = n_dec[apsp_pkg::NODE_W-1:0];
  assign a_ok  = {1'b0, a_in} < n_reg;
  assign b_ok  = {1'b0, b_in} < n_reg;

  // matrix store
  apsp_pkg::wr_req_t wr;
  apsp_pkg::addr_t   rd_addr_a;
  apsp_pkg::addr_t   rd_addr_b;
  apsp_pkg::dist_t   q_a;
  apsp_pkg::dist_t   q_b;

  apsp_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (q_a),
    .rd_data_b (q_b)
  );

  // datapath: relaxation candidate and scan sum from the read data
  apsp_pkg::dist_t via;
  apsp_pkg::dist_t sum;
  logic            relax_wr;

  assign via      = apsp_pkg::sat_add(dik, q_a);
  assign sum      = apsp_pkg::sat_add(q_a, q_b);
  assign relax_wr = pend && (via < q_b) && (state == ST_ROW || state == ST_RLAST);

  always_comb begin
    rd_addr_a = {ii, kk};
    rd_addr_b = {ii, jj};
    wr.en     = 1'b0;
    wr.addr   = {ii, jp};
    wr.data   = via;
    unique case (state)
      ST_FILL: begin
        wr.en   = 1'b1;
        wr.addr = {ii, jj};
        wr.data = (ii == jj) ? '0 : apsp_pkg::UNREACH;
      end
      ST_EDGE1: begin
        wr.en   = 1'b1;
        wr.addr = {qa, qb};
        wr.data = apsp_pkg::DIST_W'(1);
      end
      ST_EDGE2: begin
        wr.en   = 1'b1;
        wr.addr = {qb, qa};
        wr.data = apsp_pkg::DIST_W'(1);
      end
      ST_RIK: begin
        rd_addr_a = {ii, kk};
      end
      ST_ROW, ST_RLAST: begin
        // a reads d(k,j), b reads d(i,j); write back the entry in flight
        rd_addr_a = {kk, jj};
        rd_addr_b = {ii, jj};
        wr.en     = relax_wr;
      end
      ST_SCAN, ST_SLAST: begin
        rd_addr_a = {qa, ii};
        rd_addr_b = {ii, qb};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (cmd_in)
            CMD_BEGIN_L: state_next = (cnt_clamped == '0) ? ST_IDLE : ST_FILL;
            CMD_EDGE_L:  state_next = (a_ok && b_ok && a_in != b_in) ? ST_EDGE1 : ST_IDLE;
            CMD_QUERY_L: state_next = (a_ok && b_ok) ? ST_RIK : ST_OUT;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL:  if (jj == nm1 && ii == nm1) state_next = ST_IDLE;
      ST_EDGE1: state_next = ST_EDGE2;
      ST_EDGE2: state_next = ST_IDLE;
      ST_RIK:   state_next = ST_ROW;
      ST_ROW:   if (jj == nm1) state_next = ST_RLAST;
      ST_RLAST: state_next = (ii == nm1 && kk == nm1) ? ST_SCAN : ST_RIK;
      ST_SCAN:  if (ii == nm1) state_next = ST_SLAST;
      ST_SLAST: state_next = ST_OUT;
      ST_OUT:   if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n_reg <= '0;
      pend  <= 1'b0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            qa <= a_in;
            qb <= b_in;
            ii <= '0;
            jj <= '0;
            kk <= '0;
            pend <= 1'b0;
            best <= '0;
            unr  <= 1'b0;
            bad  <= !(a_ok && b_ok);
            if (cmd_in == apsp_pkg::CMD_BEGIN) begin
              n_reg <= cnt_clamped;
            end
          end
        end
        ST_FILL: begin
          if (jj == nm1) begin
            jj <= '0;
            ii <= ii + apsp_pkg::NODE_W'(1);
          end else begin
            jj <= jj + apsp_pkg::NODE_W'(1);
          end
        end
        ST_RIK: begin
          first <= 1'b1;
          pend  <= 1'b0;
          jj    <= '0;
        end
        ST_ROW: begin
          if (first) begin
            dik <= q_a;
          end
          first <= 1'b0;
          pend  <= 1'b1;
          jp    <= jj;
          if (jj != nm1) begin
            jj <= jj + apsp_pkg::NODE_W'(1);
          end
        end
        ST_RLAST: begin
          pend <= 1'b0;
          if (ii == nm1) begin
            ii <= '0;
            if (kk != nm1) begin
              kk <= kk + apsp_pkg::NODE_W'(1);
            end
          end else begin
            ii <= ii + apsp_pkg::NODE_W'(1);
          end
        end
        ST_SCAN, ST_SLAST: begin
          if (pend) begin
            if (sum == apsp_pkg::UNREACH) begin
              unr <= 1'b1;
            end else if (sum > best) begin
              best <= sum;
            end
          end
          pend <= (state == ST_SCAN);
          if (state == ST_SCAN && ii != nm1) begin
            ii <= ii + apsp_pkg::NODE_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  logic             out_valid;
  logic [15:0]      out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
      out_data  <= {6'd0, bad, unr, (unr ? apsp_pkg::DIST_W'(0) : best)};
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // checks

  // an out-of-range query goes straight to the result stage
  a_bad_query: assert property (@(posedge clk) disable iff (rst)
    (s_fire && cmd_in == apsp_pkg::CMD_QUERY && !(a_ok && b_ok)) |=> (state == ST_OUT))
    else $error("out-of-range query did not go to result stage");

  // relaxation never rewrites column k, it is fixed in iteration k
  a_col_k: assert property (@(posedge clk) disable iff (rst)
    relax_wr |-> (jp != kk))
    else $error("relaxation wrote column k");

  // the matrix is only written by fill, edge and relaxation steps
  a_wr_state: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == ST_FILL || state == ST_EDGE1 || state == ST_EDGE2 ||
               state == ST_ROW || state == ST_RLAST))
    else $error("matrix write outside a writing step");

  // a finished query is loaded into the output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!out_valid || m_axis_tready)) |=> out_valid)
    else $error("result not loaded");

  // a result never flags both a bad request and an unreachable pair
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data[8] && out_data[9]))
    else $error("both result flags set");

  // node count never exceeds the matrix size
  a_count: assert property (@(posedge clk) disable iff (rst)
    n_reg <= apsp_pkg::CNT_W'(apsp_pkg::MAX_NODES))
    else $error("node count above matrix size");

endmodule
